>>> rtl/ocls_pkg.sv
// Types and constants shared by the Ogg chain-link splitter.
// No dependencies; compile first.
package ocls_pkg;

   localparam int unsigned HDR_LEN      = 27;
   localparam logic [4:0]  HDR_LAST_POS = 5'd26;
   localparam logic [4:0]  VERSION_POS  = 5'd4;
   localparam logic [4:0]  FLAGS_POS    = 5'd5;
   localparam logic [4:0]  SERIAL_FIRST = 5'd14;
   localparam logic [4:0]  SERIAL_LAST  = 5'd17;
   localparam int unsigned FLAG_BOS_BIT = 1;
   localparam logic [15:0] LIMIT_RESET  = 16'd4096;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_TABLE   = 2'd1,
      PHASE_PAYLOAD = 2'd2,
      PHASE_STOPPED = 2'd3
   } walk_phase_type;

   typedef enum logic [2:0] {
      STOP_END_OF_DATA = 3'd0,
      STOP_BAD_HEADER  = 3'd1,
      STOP_NO_OPENING  = 3'd2,
      STOP_LIMIT       = 3'd3,
      STOP_TRUNCATED   = 3'd4
   } stop_reason_type;

   typedef struct packed {
      logic            has_link;
      logic [15:0]     link_index;
      logic [31:0]     stream_serial;
      logic            final_record;
      stop_reason_type stop_reason;
   } rec_info_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   function automatic logic [7:0] capture_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0: val = 8'h4F;
         2'd1: val = 8'h67;
         2'd2: val = 8'h67;
         2'd3: val = 8'h53;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/ocls_if.sv
// Channel interfaces of the Ogg chain-link splitter: byte input, link records, limit write.
// Depends on nothing; the record channel width follows OFFSET_BITS.
interface ocls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;
   modport source (output valid, file_byte, end_of_file, input ready);
   modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

interface ocls_rsp_if #(parameter int OFFSET_BITS = 40);
   logic                   valid;
   logic                   ready;
   logic                   has_link;
   logic [15:0]            link_index;
   logic [OFFSET_BITS-1:0] link_start;
   logic [OFFSET_BITS-1:0] link_end;
   logic [31:0]            stream_serial;
   logic                   final_record;
   logic [2:0]             stop_reason;
   modport source (output valid, has_link, link_index, link_start, link_end, stream_serial,
                   final_record, stop_reason, input ready);
   modport sink (input valid, has_link, link_index, link_start, link_end, stream_serial,
                 final_record, stop_reason, output ready);
endinterface

interface ocls_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] link_limit;
   modport source (output valid, link_limit, input ready);
   modport sink (input valid, link_limit, output ready);
endinterface

>>> rtl/ocls_front.sv
// Front end: accepts file bytes, walks page headers and segment tables, builds link records.
// Depends on ocls_pkg and ocls_if; pushes record pairs into ocls_queue.
module ocls_front import ocls_pkg::*; #(
   parameter int OFFSET_BITS = 40,
   parameter int REC_BITS    = $bits(rec_info_type) + 2 * OFFSET_BITS,
   parameter int ENTRY_BITS  = 1 + 2 * REC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   ocls_req_if.sink              req_if,
   ocls_csr_if.sink              csr_if,
   input  qstat_type             q_stat,
   output logic                  q_push,
   output logic [ENTRY_BITS-1:0] q_data
);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

   walk_phase_type         phase_ff, phase_in, phase_mid;
   logic [4:0]             hdr_pos_ff, hdr_pos_in;
   logic                   mismatch_ff, mismatch_in;
   logic                   opens_ff, opens_in;
   logic [31:0]            page_serial_ff, page_serial_in;
   logic [7:0]             table_rem_ff, table_rem_in;
   logic [7:0]             table_entries_ff, table_entries_in;
   logic [15:0]            payload_total_ff, payload_total_in;
   logic [15:0]            payload_rem_ff, payload_rem_in;
   logic [OFFSET_BITS-1:0] byte_off_ff, byte_off_in;
   logic [OFFSET_BITS-1:0] page_off_ff, page_off_in;
   logic                   open_valid_ff, open_valid_in;
   logic [OFFSET_BITS-1:0] open_start_ff, open_start_in;
   logic [OFFSET_BITS-1:0] open_end_ff, open_end_in;
   logic [31:0]            open_serial_ff, open_serial_in;
   logic [15:0]            links_ff, links_in;
   logic [15:0]            limit_ff, limit_in;

   logic                   fire;
   logic [7:0]             b;
   logic                   eof;
   logic                   hdr_first, hdr_end;
   logic [OFFSET_BITS-1:0] page_off_eff;
   logic                   mismatch_eff, opens_eff;
   logic [31:0]            serial_eff;
   logic                   finish, limit_hit, no_open, page_ok, stop_now;
   stop_reason_type        stop_code;
   logic [7:0]             entries;
   logic [15:0]            payload_t;
   logic [16:0]            page_size;
   logic [OFFSET_BITS:0]   end_sum;
   logic [OFFSET_BITS-1:0] end_new;
   logic                   mid_valid;
   logic [OFFSET_BITS-1:0] mid_start, mid_end;
   logic [31:0]            mid_serial;
   logic [15:0]            mid_links;
   logic                   emit_prev, final_now;
   rec_info_type           info_prev, info_final;
   logic [REC_BITS-1:0]    rec_prev, rec_final;
   logic [1:0]             lane;

   assign req_if.ready = !q_stat.full;
   assign csr_if.ready = 1'b1;
   assign fire = req_if.valid && req_if.ready;
   assign b    = req_if.file_byte;
   assign eof  = req_if.end_of_file;

   // classify the byte
   always_comb begin
      hdr_first    = (phase_ff == PHASE_HEADER) && (hdr_pos_ff == 5'd0);
      hdr_end      = (phase_ff == PHASE_HEADER) && (hdr_pos_ff == HDR_LAST_POS);
      page_off_eff = hdr_first ? byte_off_ff : page_off_ff;
      mismatch_eff = hdr_first ? 1'b0 : mismatch_ff;
      opens_eff    = hdr_first ? 1'b0 : opens_ff;
      serial_eff   = hdr_first ? 32'd0 : page_serial_ff;
      lane         = 2'(hdr_pos_ff - SERIAL_FIRST);
      if (phase_ff == PHASE_HEADER) begin
         if (hdr_pos_ff < VERSION_POS) begin
            if (b != capture_byte(hdr_pos_ff[1:0])) mismatch_eff = 1'b1;
         end else if (hdr_pos_ff == VERSION_POS) begin
            if (b != 8'd0) mismatch_eff = 1'b1;
         end else if (hdr_pos_ff == FLAGS_POS) begin
            opens_eff = b[FLAG_BOS_BIT];
         end else if (hdr_pos_ff >= SERIAL_FIRST && hdr_pos_ff <= SERIAL_LAST) begin
            serial_eff[{lane, 3'b000} +: 8] = b;
         end
      end
      finish = (hdr_end && !mismatch_eff && b == 8'd0)
            || (phase_ff == PHASE_TABLE && table_rem_ff == 8'd1);
      entries   = hdr_end ? 8'd0 : table_entries_ff;
      payload_t = hdr_end ? 16'd0 : 16'(payload_total_ff + 16'(b));
      limit_hit = finish && opens_eff && (links_ff >= limit_ff);
      no_open   = finish && !limit_hit && !opens_eff && !open_valid_ff;
      page_ok   = finish && !limit_hit && !no_open;
      emit_prev = page_ok && opens_eff && open_valid_ff;
      stop_now  = (hdr_end && mismatch_eff) || limit_hit || no_open;
      priority if (hdr_end && mismatch_eff) stop_code = STOP_BAD_HEADER;
      else if (limit_hit)                   stop_code = STOP_LIMIT;
      else                                  stop_code = STOP_NO_OPENING;
      page_size = 17'(HDR_LEN) + 17'(entries) + 17'(payload_t);
      end_sum   = {1'b0, page_off_eff} + (OFFSET_BITS+1)'(page_size);
      end_new   = end_sum[OFFSET_BITS] ? OFF_MAX : end_sum[OFFSET_BITS-1:0];
   end

   // next walk phase
   always_comb begin
      phase_mid = phase_ff;
      unique case (phase_ff)
         PHASE_HEADER: begin
            if (hdr_end) begin
               if (mismatch_eff)     phase_mid = PHASE_STOPPED;
               else if (b != 8'd0)   phase_mid = PHASE_TABLE;
            end
         end
         PHASE_TABLE: phase_mid = PHASE_TABLE;
         PHASE_PAYLOAD: begin
            if (payload_rem_ff == 16'd1) phase_mid = PHASE_HEADER;
         end
         PHASE_STOPPED: phase_mid = PHASE_STOPPED;
         default: phase_mid = PHASE_STOPPED;
      endcase
      if (finish) begin
         if (!page_ok)                 phase_mid = PHASE_STOPPED;
         else if (payload_t != 16'd0)  phase_mid = PHASE_PAYLOAD;
         else                          phase_mid = PHASE_HEADER;
      end
      phase_in = eof ? PHASE_HEADER : phase_mid;
   end

   // datapath next values
   always_comb begin
      hdr_pos_in       = hdr_pos_ff;
      mismatch_in      = mismatch_ff;
      opens_in         = opens_ff;
      page_serial_in   = page_serial_ff;
      page_off_in      = page_off_ff;
      table_rem_in     = table_rem_ff;
      table_entries_in = table_entries_ff;
      payload_total_in = payload_total_ff;
      payload_rem_in   = payload_rem_ff;
      if (phase_ff == PHASE_HEADER) begin
         hdr_pos_in     = hdr_end ? 5'd0 : 5'(hdr_pos_ff + 5'd1);
         mismatch_in    = mismatch_eff;
         opens_in       = opens_eff;
         page_serial_in = serial_eff;
         page_off_in    = page_off_eff;
         if (hdr_end && !mismatch_eff) begin
            table_rem_in     = b;
            table_entries_in = b;
            payload_total_in = 16'd0;
         end
      end
      if (phase_ff == PHASE_TABLE) begin
         table_rem_in     = 8'(table_rem_ff - 8'd1);
         payload_total_in = payload_t;
      end
      if (phase_ff == PHASE_PAYLOAD) payload_rem_in = 16'(payload_rem_ff - 16'd1);
      if (page_ok && payload_t != 16'd0) payload_rem_in = payload_t;

      mid_valid  = open_valid_ff;
      mid_start  = open_start_ff;
      mid_end    = open_end_ff;
      mid_serial = open_serial_ff;
      mid_links  = links_ff;
      if (page_ok) begin
         mid_valid = 1'b1;
         mid_end   = end_new;
         if (opens_eff) begin
            mid_start  = page_off_eff;
            mid_serial = serial_eff;
            mid_links  = 16'(links_ff + 16'd1);
         end
      end
      open_valid_in  = mid_valid;
      open_start_in  = mid_start;
      open_end_in    = mid_end;
      open_serial_in = mid_serial;
      links_in       = mid_links;
      byte_off_in    = (byte_off_ff != OFF_MAX) ? byte_off_ff + 1'b1 : byte_off_ff;
      limit_in       = (csr_if.valid && csr_if.ready) ? csr_if.link_limit : limit_ff;
      if (eof) begin
         hdr_pos_in       = 5'd0;
         mismatch_in      = 1'b0;
         opens_in         = 1'b0;
         page_serial_in   = 32'd0;
         page_off_in      = '0;
         table_rem_in     = 8'd0;
         table_entries_in = 8'd0;
         payload_total_in = 16'd0;
         payload_rem_in   = 16'd0;
         open_valid_in    = 1'b0;
         open_start_in    = '0;
         open_end_in      = '0;
         open_serial_in   = 32'd0;
         links_in         = 16'd0;
         byte_off_in      = '0;
      end
   end

   // records for the queue
   always_comb begin
      final_now = stop_now || (eof && phase_mid != PHASE_STOPPED);

      info_prev.has_link      = 1'b1;
      info_prev.link_index    = 16'(links_ff - 16'd1);
      info_prev.stream_serial = open_serial_ff;
      info_prev.final_record  = 1'b0;
      info_prev.stop_reason   = STOP_END_OF_DATA;
      rec_prev = {info_prev, open_start_ff, open_end_ff};

      info_final.has_link      = mid_valid;
      info_final.link_index    = mid_valid ? 16'(mid_links - 16'd1) : 16'd0;
      info_final.stream_serial = mid_valid ? mid_serial : 32'd0;
      info_final.final_record  = 1'b1;
      if (stop_now)                        info_final.stop_reason = stop_code;
      else if (phase_mid == PHASE_TABLE)   info_final.stop_reason = STOP_TRUNCATED;
      else                                 info_final.stop_reason = STOP_END_OF_DATA;
      rec_final = {info_final, mid_valid ? mid_start : '0, mid_valid ? mid_end : '0};

      q_push = fire && (emit_prev || final_now);
      if (emit_prev) q_data = {final_now, rec_prev, rec_final};
      else           q_data = {1'b0, rec_final, rec_final};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_HEADER;
         hdr_pos_ff       <= 5'd0;
         mismatch_ff      <= 1'b0;
         opens_ff         <= 1'b0;
         page_serial_ff   <= 32'd0;
         page_off_ff      <= '0;
         table_rem_ff     <= 8'd0;
         table_entries_ff <= 8'd0;
         payload_total_ff <= 16'd0;
         payload_rem_ff   <= 16'd0;
         byte_off_ff      <= '0;
         open_valid_ff    <= 1'b0;
         open_start_ff    <= '0;
         open_end_ff      <= '0;
         open_serial_ff   <= 32'd0;
         links_ff         <= 16'd0;
         limit_ff         <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
         if (fire) begin
            phase_ff         <= phase_in;
            hdr_pos_ff       <= hdr_pos_in;
            mismatch_ff      <= mismatch_in;
            opens_ff         <= opens_in;
            page_serial_ff   <= page_serial_in;
            page_off_ff      <= page_off_in;
            table_rem_ff     <= table_rem_in;
            table_entries_ff <= table_entries_in;
            payload_total_ff <= payload_total_in;
            payload_rem_ff   <= payload_rem_in;
            byte_off_ff      <= byte_off_in;
            open_valid_ff    <= open_valid_in;
            open_start_ff    <= open_start_in;
            open_end_ff      <= open_end_in;
            open_serial_ff   <= open_serial_in;
            links_ff         <= links_in;
         end
      end
   end

endmodule

>>> rtl/ocls_queue.sv
// Short queue of record pairs between the front end and the output stage.
// Depends on ocls_pkg for the status struct.
module ocls_queue import ocls_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output qstat_type        q_stat
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
      q_stat.empty = (count_ff == '0);
      q_stat.full  = (count_ff == CNT_BITS'(DEPTH));
      pop_data     = slots_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/ocls_back.sv
// Output stage: splits queued record pairs into single beats behind an output register.
// Depends on ocls_pkg and ocls_if; pops ocls_queue.
module ocls_back import ocls_pkg::*; #(
   parameter int OFFSET_BITS = 40,
   parameter int REC_BITS    = $bits(rec_info_type) + 2 * OFFSET_BITS,
   parameter int ENTRY_BITS  = 1 + 2 * REC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qstat_type             q_stat,
   input  logic [ENTRY_BITS-1:0] q_data,
   output logic                  q_pop,
   ocls_rsp_if.source            rsp_if
);

   localparam int INFO_BITS = $bits(rec_info_type);

   logic                   valid_ff, valid_in;
   logic                   sel_ff, sel_in;
   rec_info_type           info_ff, info_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] end_ff, end_in;
   logic                   load, two;
   logic [REC_BITS-1:0]    rec;

   always_comb begin
      two      = q_data[ENTRY_BITS-1];
      rec      = sel_ff ? q_data[REC_BITS-1:0] : q_data[2*REC_BITS-1 -: REC_BITS];
      load     = !q_stat.empty && (!valid_ff || rsp_if.ready);
      q_pop    = load && (sel_ff || !two);
      sel_in   = load ? (!sel_ff && two) : sel_ff;
      valid_in = load ? 1'b1 : (valid_ff && !rsp_if.ready);
      info_in  = load ? rec_info_type'(rec[REC_BITS-1 -: INFO_BITS]) : info_ff;
      start_in = load ? rec[2*OFFSET_BITS-1 -: OFFSET_BITS] : start_ff;
      end_in   = load ? rec[OFFSET_BITS-1:0] : end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      info_ff  <= info_in;
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.has_link      = info_ff.has_link;
   assign rsp_if.link_index    = info_ff.link_index;
   assign rsp_if.link_start    = start_ff;
   assign rsp_if.link_end      = end_ff;
   assign rsp_if.stream_serial = info_ff.stream_serial;
   assign rsp_if.final_record  = info_ff.final_record;
   assign rsp_if.stop_reason   = info_ff.stop_reason;

endmodule

>>> rtl/ogg_chain_link_splitter_core.sv
// Top level of the Ogg chain-link splitter: front end, record queue, output stage.
// Depends on ocls_pkg, ocls_if, ocls_front, ocls_queue and ocls_back.
//
// Takes one file byte per cycle and emits one record per link, plus a final record with
// the stop reason at the end of the file. The front end walks page headers and segment
// tables combinationally on each accepted byte. A byte that both closes a link and ends
// the walk yields two records, which the output stage sends as two separate beats; the
// QUEUE_DEPTH-entry queue absorbs this, so input stalls only when the record side backs
// up. Output records leave from a register loaded from the head of the queue. The link
// limit may be written any time the block is idle.
module ogg_chain_link_splitter_core import ocls_pkg::*; #(
   parameter int OFFSET_BITS = 40,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   ocls_req_if.sink   req_if,
   ocls_rsp_if.source rsp_if,
   ocls_csr_if.sink   csr_if
);

   localparam int REC_BITS   = $bits(rec_info_type) + 2 * OFFSET_BITS;
   localparam int ENTRY_BITS = 1 + 2 * REC_BITS;

   qstat_type             q_stat;
   logic                  q_push, q_pop;
   logic [ENTRY_BITS-1:0] q_push_data, q_pop_data;

   ocls_front #(
      .OFFSET_BITS(OFFSET_BITS), .REC_BITS(REC_BITS), .ENTRY_BITS(ENTRY_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .csr_if (csr_if),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   ocls_queue #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_stat    (q_stat)
   );

   ocls_back #(
      .OFFSET_BITS(OFFSET_BITS), .REC_BITS(REC_BITS), .ENTRY_BITS(ENTRY_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .q_data (q_pop_data),
      .q_pop  (q_pop),
      .rsp_if (rsp_if)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("record pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("record popped from empty queue");

   a_empty_record: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.has_link) |->
         (rsp_if.final_record && rsp_if.link_index == 16'd0 && rsp_if.stream_serial == 32'd0))
      else $error("record without link is not an empty final record");

   a_reason_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.final_record) |-> (rsp_if.stop_reason == STOP_END_OF_DATA))
      else $error("stop reason on a non-final record");

endmodule

>>> test/ocls_link_checker.sv
// Link record checker for the Ogg chain-link splitter: follows the byte walk on every
// accepted input beat, queues the records it implies and compares each output beat.
// Depends on ocls_pkg and the channel interfaces in ocls_if.
`timescale 1ns / 100ps

module ocls_link_checker import ocls_pkg::*; #(
   parameter int OFFSET_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   ocls_req_if         req,
   ocls_rsp_if         rsp,
   ocls_csr_if         csr,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
   localparam logic [31:0] CAPTURE_WORD = "OggS";

   typedef struct packed {
      logic                   has_link;
      logic [15:0]            link_index;
      logic [OFFSET_BITS-1:0] link_start;
      logic [OFFSET_BITS-1:0] link_end;
      logic [31:0]            stream_serial;
      logic                   final_record;
      stop_reason_type        stop_reason;
   } link_record_type;

   link_record_type link_records_due[$];

   logic [15:0]            limit_reg;
   walk_phase_type         phase;
   logic [4:0]             hdr_pos;
   logic                   hdr_bad;
   logic                   page_bos;
   logic [31:0]            page_ser;
   logic [7:0]             tbl_left;
   logic [7:0]             tbl_count;
   logic [15:0]            pay_total;
   logic [15:0]            pay_left;
   logic [OFFSET_BITS-1:0] file_pos;
   logic [OFFSET_BITS-1:0] page_pos;
   logic                   link_open;
   logic [OFFSET_BITS-1:0] link_from;
   logic [OFFSET_BITS-1:0] link_to;
   logic [31:0]            link_ser;
   logic [15:0]            link_count;

   task clear_walk();
      phase      = PHASE_HEADER;
      hdr_pos    = '0;
      hdr_bad    = 1'b0;
      page_bos   = 1'b0;
      page_ser   = '0;
      tbl_left   = '0;
      tbl_count  = '0;
      pay_total  = '0;
      pay_left   = '0;
      file_pos   = '0;
      page_pos   = '0;
      link_open  = 1'b0;
      link_from  = '0;
      link_to    = '0;
      link_ser   = '0;
      link_count = '0;
   endtask

   task queue_record(input logic fin, input stop_reason_type why);
      link_record_type rec;
      rec = '0;
      if (link_open) begin
         rec.has_link      = 1'b1;
         rec.link_index    = link_count - 16'd1;
         rec.link_start    = link_from;
         rec.link_end      = link_to;
         rec.stream_serial = link_ser;
      end
      rec.final_record = fin;
      rec.stop_reason  = fin ? why : STOP_END_OF_DATA;
      link_records_due.insert(link_records_due.size(), rec);
   endtask

   task halt_walk(input stop_reason_type why);
      queue_record(1'b1, why);
      phase = PHASE_STOPPED;
   endtask

   task close_page();
      logic [OFFSET_BITS:0] page_size;
      if (page_bos) begin
         if (link_count >= limit_reg) begin
            halt_walk(STOP_LIMIT);
            return;
         end
         if (link_open) queue_record(1'b0, STOP_END_OF_DATA);
         link_open  = 1'b1;
         link_from  = page_pos;
         link_ser   = page_ser;
         link_count = link_count + 16'd1;
      end
      if (!link_open) begin
         halt_walk(STOP_NO_OPENING);
         return;
      end
      page_size = HDR_LEN + tbl_count + pay_total;
      if ({1'b0, page_pos} > {1'b0, OFF_MAX} - page_size) link_to = OFF_MAX;
      else link_to = page_pos + page_size[OFFSET_BITS-1:0];
      if (pay_total != 0) begin
         pay_left = pay_total;
         phase    = PHASE_PAYLOAD;
      end else begin
         phase = PHASE_HEADER;
      end
   endtask

   task take_header_byte(input logic [7:0] b);
      if (hdr_pos == 0) begin
         page_pos = file_pos;
         hdr_bad  = 1'b0;
         page_bos = 1'b0;
         page_ser = '0;
      end
      if (hdr_pos < 4) begin
         if (b != CAPTURE_WORD[8*(3-hdr_pos) +: 8]) hdr_bad = 1'b1;
      end else if (hdr_pos == VERSION_POS) begin
         if (b != 8'd0) hdr_bad = 1'b1;
      end else if (hdr_pos == FLAGS_POS) begin
         page_bos = b[FLAG_BOS_BIT];
      end else if (hdr_pos >= SERIAL_FIRST && hdr_pos <= SERIAL_LAST) begin
         page_ser[8*(hdr_pos-SERIAL_FIRST) +: 8] = b;
      end
      if (hdr_pos != HDR_LAST_POS) begin
         hdr_pos = hdr_pos + 5'd1;
         return;
      end
      hdr_pos = '0;
      if (hdr_bad) begin
         halt_walk(STOP_BAD_HEADER);
         return;
      end
      tbl_count = b;
      tbl_left  = b;
      pay_total = '0;
      if (b == 8'd0) close_page();
      else phase = PHASE_TABLE;
   endtask

   task walk_byte(input logic [7:0] b, input logic last);
      case (phase)
         PHASE_HEADER: take_header_byte(b);
         PHASE_TABLE: begin
            pay_total = pay_total + b;
            tbl_left  = tbl_left - 8'd1;
            if (tbl_left == 0) close_page();
         end
         PHASE_PAYLOAD: begin
            pay_left = pay_left - 16'd1;
            if (pay_left == 0) phase = PHASE_HEADER;
         end
         default: ;
      endcase
      if (last) begin
         if (phase == PHASE_TABLE) halt_walk(STOP_TRUNCATED);
         else if (phase != PHASE_STOPPED) halt_walk(STOP_END_OF_DATA);
         clear_walk();
      end else if (file_pos != OFF_MAX) begin
         file_pos = file_pos + 1'b1;
      end
   endtask

   task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      link_record_type want;
      if (reset) begin
         clear_walk();
         limit_reg = LIMIT_RESET;
         link_records_due.delete();
      end else begin
         if (csr.valid && csr.ready) limit_reg = csr.link_limit;
         if (req.valid && req.ready) walk_byte(req.file_byte, req.end_of_file);
         if (rsp.valid && rsp.ready) begin
            if (link_records_due.size() == 0) begin
               $error("record beat with none expected: has_link %0b index %0d final %0b",
                      rsp.has_link, rsp.link_index, rsp.final_record);
               fail_count++;
            end else begin
               want = link_records_due.pop_front();
               check_field("has_link", want.has_link, rsp.has_link);
               check_field("link_index", want.link_index, rsp.link_index);
               check_field("link_start", want.link_start, rsp.link_start);
               check_field("link_end", want.link_end, rsp.link_end);
               check_field("stream_serial", want.stream_serial, rsp.stream_serial);
               check_field("final_record", want.final_record, rsp.final_record);
               check_field("stop_reason", want.stop_reason, rsp.stop_reason);
            end
         end
      end
      pending <= link_records_due.size();
   end

endmodule

>>> test/ogg_chain_link_splitter_core_tb.sv
// Testbench top for the Ogg chain-link splitter: builds Ogg files page by page, feeds them
// byte by byte with random gaps, stalls the record side and gives the verdict.
// Depends on ocls_pkg, ocls_if, the splitter RTL and ocls_link_checker.
`timescale 1ns / 100ps

module ogg_chain_link_splitter_core_tb;
   import ocls_pkg::*;

   localparam int OFFSET_BITS    = 40;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 120;
   localparam int RANDOM_RECORDS = 4;
   localparam logic [31:0] CAPTURE_WORD = "OggS";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        tx_gaps = 1'b1;
   logic        rx_gaps = 1'b1;
   logic        hold_request = 1'b0;
   int unsigned mismatches;
   int unsigned pending;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_made = 0;
   int unsigned records_made = 0;
   logic [7:0]  file_q[$];
   int          page_starts[$];

   ocls_req_if req_if ();
   ocls_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) rsp_if ();
   ocls_csr_if csr_if ();

   ogg_chain_link_splitter_core #(.OFFSET_BITS(OFFSET_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   ocls_link_checker #(.OFFSET_BITS(OFFSET_BITS)) link_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr        (csr_if),
      .fail_count (mismatches),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            gap = LONG_HOLD;
            hold_request = 1'b0;
         end else begin
            gap = rx_gaps ? $urandom_range(0, 8) : 0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.file_byte   <= b;
      req_if.end_of_file <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic append_byte(input logic [7:0] value);
      file_q.insert(file_q.size(), value);
   endtask

   task automatic add_page(input logic bos, input logic [31:0] serial, input int segs,
                           input int min_len, input int max_len);
      int         payload;
      logic [7:0] len;
      payload = 0;
      page_starts.insert(page_starts.size(), file_q.size());
      for (int i = 3; i >= 0; i--) append_byte(CAPTURE_WORD[8*i +: 8]);
      append_byte(8'd0);
      append_byte((8'($urandom_range(0, 255)) & 8'hFD) | {6'd0, bos, 1'b0});
      repeat (8) append_byte(8'($urandom_range(0, 255)));
      for (int i = 0; i < 4; i++) append_byte(serial[8*i +: 8]);
      repeat (8) append_byte(8'($urandom_range(0, 255)));
      append_byte(segs[7:0]);
      repeat (segs) begin
         len = 8'($urandom_range(min_len, max_len));
         append_byte(len);
         payload += len;
      end
      repeat (payload) append_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic cut_file(input int keep);
      while (file_q.size() > keep) void'(file_q.pop_back());
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) push_byte(file_q[i], i == file_q.size() - 1);
      bytes_made += file_q.size();
      records_made++;
      file_q.delete();
      page_starts.delete();
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      settle();
      csr_if.valid      <= 1'b1;
      csr_if.link_limit <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_random_file();
      int kind;
      int n_links;
      int at;
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      kind    = $urandom_range(0, 9);
      n_links = $urandom_range(1, 3);
      for (int l = 0; l < n_links; l++) begin
         for (int p = $urandom_range(1, 2); p > 0; p--) begin
            add_page(p == 1 ? 1'b0 : 1'b0, $urandom, 0, 0, 0);
            file_q.delete();
            page_starts.pop_back();
         end
      end
      for (int l = 0; l < n_links; l++) begin
         for (int p = 0, n = $urandom_range(1, 2); p < n; p++) begin
            add_page(p == 0, $urandom, $urandom_range(0, 3), 0,
                     ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 7));
         end
      end
      records_made += n_links;
      case (kind)
         6: begin
            file_q.delete();
            repeat ($urandom_range(1, 60)) append_byte(8'($urandom_range(0, 255)));
         end
         7: begin
            at = page_starts[$urandom_range(0, page_starts.size() - 1)] + $urandom_range(0, 4);
            file_q[at] = file_q[at] ^ (8'd1 << $urandom_range(0, 7));
         end
         8: cut_file($urandom_range(1, file_q.size()));
         9: file_q[FLAGS_POS][FLAG_BOS_BIT] = 1'b0;
         default: ;
      endcase
      send_file();
   endtask

   initial begin
      req_if.valid       <= 1'b0;
      req_if.file_byte   <= 8'd0;
      req_if.end_of_file <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.link_limit  <= 16'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone end-of-file byte
      append_byte(8'hFF);
      send_file();
      // bad capture, then trailing bytes to ignore
      add_page(1'b1, $urandom, 1, 0, 7);
      file_q[2] = 8'h58;
      append_byte(8'h00);
      send_file();
      // bad version
      add_page(1'b1, $urandom, 0, 0, 0);
      file_q[VERSION_POS] = 8'h80;
      send_file();
      // no opening page
      add_page(1'b0, $urandom, 2, 0, 7);
      add_page(1'b1, $urandom, 0, 0, 0);
      send_file();
      // two links, serial extremes, flag bytes with all other bits set
      add_page(1'b1, 32'hFFFF_FFFF, 0, 0, 0);
      file_q[FLAGS_POS] = 8'hFF;
      add_page(1'b0, 32'hFFFF_FFFF, 3, 0, 7);
      add_page(1'b1, 32'h0000_0000, 1, 0, 0);
      add_page(1'b0, 32'h0000_0000, 2, 0, 7);
      file_q[page_starts[3] + FLAGS_POS] = 8'hFD;
      send_file();
      // full-length segment table cut off
      add_page(1'b1, $urandom, 0, 0, 0);
      add_page(1'b0, $urandom, 255, 0, 7);
      cut_file(page_starts[1] + HDR_LEN + 2);
      send_file();
      // header cut off
      add_page(1'b1, $urandom, 0, 0, 0);
      add_page(1'b0, $urandom, 0, 0, 0);
      cut_file(page_starts[1] + 10);
      send_file();
      // payload running past the end
      add_page(1'b1, $urandom, 2, 1, 7);
      cut_file(file_q.size() - 1);
      send_file();

      write_limit(16'd1);
      add_page(1'b1, $urandom, 1, 0, 7);
      add_page(1'b1, $urandom, 0, 0, 0);
      add_page(1'b0, $urandom, 0, 0, 0);
      send_file();
      add_page(1'b1, $urandom, 0, 0, 0);
      send_file();

      write_limit(16'hFFFF);
      bytes_made   = 0;
      records_made = 0;
      while (bytes_made < RANDOM_BYTES / 2 || records_made < RANDOM_RECORDS / 2)
         send_random_file();
      // hold the record side while short files stream in
      tx_gaps = 1'b0;
      hold_request = 1'b1;
      repeat (10) begin
         add_page(1'b1, $urandom, 0, 0, 0);
         cut_file($urandom_range(1, 4));
         send_file();
      end

      write_limit(16'($urandom_range(2, 3)));
      bytes_made   = 0;
      records_made = 0;
      while (bytes_made < RANDOM_BYTES / 2 || records_made < RANDOM_RECORDS / 2)
         send_random_file();

      settle();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
